// ===== rtl/core/rpf_pkg.sv =====
// shared types, constants, format decode and stride helpers for the ramdac palette/format block
`default_nettype none

package rpf_pkg;

  localparam int unsigned PaletteEntries = 256;
  localparam int unsigned PalAddrW       = (PaletteEntries > 1) ? $clog2(PaletteEntries) : 1;

  // reset values
  localparam logic [15:0] RowWordsReset = 16'd160;
  localparam logic [19:0] StrideReset   = 20'd640;

  // pixel format codes
  localparam logic [2:0] Fmt8Bpp  = 3'd3;
  localparam logic [2:0] Fmt32Bpp = 3'd4;

  // format register: bit 1 selects packed 32 bpp when bits 4:3 say 8 bpp
  localparam int unsigned FmtPackedBit = 1;
  localparam logic [1:0]  FmtField8Bpp = 2'd3;

  // floor(x / 3) for x below 2^21: (x * ceil(2^22 / 3)) >> 22
  localparam logic [20:0] Div3Recip = 21'd1398102;
  localparam int unsigned Div3Shift = 22;

  typedef enum logic [2:0] {
    OP_INDEX_WR  = 3'd0,
    OP_DATA_WR   = 3'd1,
    OP_FORMAT_WR = 3'd2,
    OP_ROWS_WR   = 3'd3,
    OP_READ_IDX  = 3'd4,
    OP_READ_FMT  = 3'd5,
    OP_LOOKUP    = 3'd6,
    OP_READ_ROWS = 3'd7
  } op_e;

  typedef enum logic [2:0] {
    PH_RED   = 3'b001,
    PH_GREEN = 3'b010,
    PH_BLUE  = 3'b100
  } phase_e;

  typedef struct packed {
    logic [2:0]  op;
    logic [15:0] value;
    logic [7:0]  lookup_index;
  } in_word_t;

  typedef struct packed {
    logic [15:0] read_data;
    logic [23:0] palette_rgb;
    logic [2:0]  pixel_format;
    logic [19:0] row_stride;
    logic        changed;
  } out_word_t;

  function automatic logic [2:0] decode_format(input logic [15:0] reg_val);
    logic [2:0] f;
    f = {1'b0, reg_val[4:3]};
    if (reg_val[4:3] == FmtField8Bpp && reg_val[FmtPackedBit]) begin
      f = Fmt32Bpp;
    end
    return f;
  endfunction

  function automatic logic [19:0] stride_for(input logic [2:0] fmt, input logic [15:0] words);
    logic [20:0] x;
    logic [41:0] prod;
    logic [19:0] s;
    x    = {words, 5'b0};
    prod = 42'(x) * 42'(Div3Recip);
    if (fmt == Fmt32Bpp) begin
      s = prod[Div3Shift +: 20];
    end else begin
      s = {2'b0, words, 2'b0};
    end
    return s;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/rpf_ram.sv =====
// generic single write port ram with registered read
`default_nettype none

module rpf_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/core/ramdac_palette_and_format_registers.sv =====
// ramdac palette loader with pixel format and row stride registers
//
//  port group   direction  word type             handshake
//  in_*         in         rpf_pkg::in_word_t    in_valid_i / in_stall_o
//  out_*        out        rpf_pkg::out_word_t   out_valid_o / out_stall_i
//
// one word per cycle; each access is decoded and applied in the cycle it is
// taken, and its result appears in the next cycle from the result register
// and the palette ram read port. input stalls only while a result waits.
// reset loads the grayscale ramp through per-entry valid bits, so there is
// no clearing pass and words are taken right after reset.
`default_nettype none

module ramdac_palette_and_format_registers (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire rpf_pkg::in_word_t  in_word_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output rpf_pkg::out_word_t      out_word_o
);

  localparam int unsigned AW = rpf_pkg::PalAddrW;

  logic in_acc;
  logic out_free;

  // architectural state
  logic [7:0]          pal_index_q, pal_index_d;
  rpf_pkg::phase_e     phase_q, phase_d;
  logic [7:0]          pend_red_q, pend_red_d;
  logic [7:0]          pend_green_q, pend_green_d;
  logic [15:0]         fmt_reg_q, fmt_reg_d;
  logic [15:0]         row_words_q, row_words_d;
  logic [2:0]          cur_fmt_q, cur_fmt_d;
  logic [19:0]         cur_stride_q, cur_stride_d;
  logic [rpf_pkg::PaletteEntries-1:0] ent_valid_q;

  // result register
  logic        out_valid_q;
  logic [15:0] rd_q, rd_d;
  logic        chg_q, chg_d;
  logic        look_hit_q, look_hit_d;
  logic        look_valid_q;
  logic [7:0]  look_idx_q;

  // palette ram
  logic          pal_we;
  logic [23:0]   pal_wdata;
  logic [23:0]   pal_rdata;
  logic [AW-1:0] pal_waddr;
  logic [AW-1:0] pal_raddr;
  logic          wr_in_range;

  logic [2:0]  new_fmt;
  logic [2:0]  stride_fmt;
  logic [15:0] stride_words;
  logic [19:0] stride_new;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = !out_free;
  assign in_acc     = in_valid_i && out_free;

  assign pal_waddr   = pal_index_q[AW-1:0];
  assign pal_raddr   = in_word_i.lookup_index[AW-1:0];
  assign wr_in_range = {1'b0, pal_index_q} < 9'(rpf_pkg::PaletteEntries);
  assign pal_wdata   = {pend_red_q, pend_green_q, in_word_i.value[7:0]};

  assign new_fmt = rpf_pkg::decode_format(in_word_i.value);

  // one stride unit, fed by either a format or a row-words write
  always_comb begin
    if (rpf_pkg::op_e'(in_word_i.op) == rpf_pkg::OP_ROWS_WR) begin
      stride_fmt   = cur_fmt_q;
      stride_words = in_word_i.value;
    end else begin
      stride_fmt   = new_fmt;
      stride_words = row_words_q;
    end
  end

  assign stride_new = rpf_pkg::stride_for(stride_fmt, stride_words);

  always_comb begin
    pal_index_d  = pal_index_q;
    phase_d      = phase_q;
    pend_red_d   = pend_red_q;
    pend_green_d = pend_green_q;
    fmt_reg_d    = fmt_reg_q;
    row_words_d  = row_words_q;
    cur_fmt_d    = cur_fmt_q;
    cur_stride_d = cur_stride_q;
    rd_d         = 16'd0;
    chg_d        = 1'b0;
    look_hit_d   = 1'b0;
    pal_we       = 1'b0;
    case (rpf_pkg::op_e'(in_word_i.op))
      rpf_pkg::OP_INDEX_WR: begin
        pal_index_d = in_word_i.value[7:0];
        phase_d     = rpf_pkg::PH_RED;
      end
      rpf_pkg::OP_DATA_WR: begin
        case (phase_q)
          rpf_pkg::PH_RED: begin
            pend_red_d = in_word_i.value[7:0];
            phase_d    = rpf_pkg::PH_GREEN;
          end
          rpf_pkg::PH_GREEN: begin
            pend_green_d = in_word_i.value[7:0];
            phase_d      = rpf_pkg::PH_BLUE;
          end
          default: begin
            pal_we      = wr_in_range;
            pal_index_d = pal_index_q + 8'd1;
            phase_d     = rpf_pkg::PH_RED;
            chg_d       = 1'b1;
          end
        endcase
      end
      rpf_pkg::OP_FORMAT_WR: begin
        fmt_reg_d = in_word_i.value;
        if (new_fmt != cur_fmt_q) begin
          cur_fmt_d    = new_fmt;
          cur_stride_d = stride_new;
          chg_d        = 1'b1;
        end
      end
      rpf_pkg::OP_ROWS_WR: begin
        row_words_d  = in_word_i.value;
        cur_stride_d = stride_new;
        chg_d        = 1'b1;
      end
      rpf_pkg::OP_READ_IDX: rd_d = {8'd0, pal_index_q};
      rpf_pkg::OP_READ_FMT: rd_d = fmt_reg_q;
      rpf_pkg::OP_LOOKUP: begin
        look_hit_d = {1'b0, in_word_i.lookup_index} < 9'(rpf_pkg::PaletteEntries);
      end
      default: rd_d = row_words_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pal_index_q  <= 8'd0;
      phase_q      <= rpf_pkg::PH_RED;
      pend_red_q   <= 8'd0;
      pend_green_q <= 8'd0;
      fmt_reg_q    <= 16'd0;
      row_words_q  <= rpf_pkg::RowWordsReset;
      cur_fmt_q    <= rpf_pkg::Fmt8Bpp;
      cur_stride_q <= rpf_pkg::StrideReset;
      ent_valid_q  <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (in_acc) begin
        pal_index_q  <= pal_index_d;
        phase_q      <= phase_d;
        pend_red_q   <= pend_red_d;
        pend_green_q <= pend_green_d;
        fmt_reg_q    <= fmt_reg_d;
        row_words_q  <= row_words_d;
        cur_fmt_q    <= cur_fmt_d;
        cur_stride_q <= cur_stride_d;
        if (pal_we) begin
          ent_valid_q[pal_waddr] <= 1'b1;
        end
      end
      if (in_acc) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result payload, held while the output stalls
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      rd_q         <= rd_d;
      chg_q        <= chg_d;
      look_hit_q   <= look_hit_d;
      look_idx_q   <= in_word_i.lookup_index;
      look_valid_q <= ent_valid_q[pal_raddr];
    end
  end

  rpf_ram #(
    .Width (24),
    .Depth (rpf_pkg::PaletteEntries)
  ) u_pal_ram (
    .clk_i   (clk_i),
    .we_i    (in_acc && pal_we),
    .waddr_i (pal_waddr),
    .wdata_i (pal_wdata),
    .re_i    (in_acc),
    .raddr_i (pal_raddr),
    .rdata_o (pal_rdata)
  );

  always_comb begin
    out_word_o.read_data    = rd_q;
    out_word_o.pixel_format = cur_fmt_q;
    out_word_o.row_stride   = cur_stride_q;
    out_word_o.changed      = chg_q;
    // an entry never loaded still holds its grayscale reset value
    if (!look_hit_q) begin
      out_word_o.palette_rgb = 24'd0;
    end else if (look_valid_q) begin
      out_word_o.palette_rgb = pal_rdata;
    end else begin
      out_word_o.palette_rgb = {look_idx_q, look_idx_q, look_idx_q};
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// ===== tb/palette_format_checker.sv =====
// checker for the ramdac palette/format block: predicts each result word and compares it
module palette_format_checker
  import rpf_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  input  wire logic      in_stall_i,
  input  wire in_word_t  in_word_i,
  input  wire logic      out_valid_i,
  input  wire logic      out_stall_i,
  input  wire out_word_t out_word_i,
  output int             errors_o,
  output int             pending_o
);

  typedef enum logic [1:0] {
    TAKE_RED,
    TAKE_GREEN,
    TAKE_BLUE
  } color_step_e;

  logic [23:0] clut [256];
  logic [7:0]  wr_index;
  color_step_e rgb_step;
  logic [7:0]  red_hold;
  logic [7:0]  green_hold;
  logic [15:0] fmt_reg;
  logic [15:0] words_reg;
  logic [2:0]  fmt_cur;
  logic [19:0] stride_cur;

  out_word_t expected_results [$];

  initial begin
    errors_o  = 0;
    pending_o = 0;
  end

  function automatic logic [19:0] bytes_per_row(input logic [2:0] fmt, input logic [15:0] words);
    logic [20:0] bits32;
    bits32 = {words, 5'b0};
    if (fmt == Fmt32Bpp) begin
      return 20'(bits32 / 21'd3);
    end
    return {2'b00, words, 2'b00};
  endfunction

  function automatic void reset_registers();
    for (int i = 0; i < 256; i++) begin
      clut[i] = {3{i[7:0]}};
    end
    wr_index   = '0;
    rgb_step   = TAKE_RED;
    red_hold   = '0;
    green_hold = '0;
    fmt_reg    = '0;
    words_reg  = RowWordsReset;
    fmt_cur    = Fmt8Bpp;
    stride_cur = StrideReset;
  endfunction

  // applies one register access to the shadow state and returns its result word
  function automatic out_word_t apply_access(input in_word_t w);
    out_word_t  r;
    logic [2:0] f;
    r = '0;
    case (op_e'(w.op))
      OP_INDEX_WR: begin
        wr_index = w.value[7:0];
        rgb_step = TAKE_RED;
      end
      OP_DATA_WR: begin
        if (rgb_step == TAKE_RED) begin
          red_hold = w.value[7:0];
          rgb_step = TAKE_GREEN;
        end else if (rgb_step == TAKE_GREEN) begin
          green_hold = w.value[7:0];
          rgb_step   = TAKE_BLUE;
        end else begin
          if (wr_index < PaletteEntries) begin
            clut[wr_index] = {red_hold, green_hold, w.value[7:0]};
          end
          wr_index  = wr_index + 8'd1;
          rgb_step  = TAKE_RED;
          r.changed = 1'b1;
        end
      end
      OP_FORMAT_WR: begin
        fmt_reg = w.value;
        f = {1'b0, w.value[4:3]};
        if (w.value[4:3] == FmtField8Bpp && w.value[FmtPackedBit]) begin
          f = Fmt32Bpp;
        end
        // raw value is kept even when the decoded format stays the same
        if (f != fmt_cur) begin
          fmt_cur    = f;
          stride_cur = bytes_per_row(f, words_reg);
          r.changed  = 1'b1;
        end
      end
      OP_ROWS_WR: begin
        words_reg  = w.value;
        stride_cur = bytes_per_row(fmt_cur, w.value);
        r.changed  = 1'b1;
      end
      OP_READ_IDX:  r.read_data = {8'h00, wr_index};
      OP_READ_FMT:  r.read_data = fmt_reg;
      OP_LOOKUP: begin
        if (w.lookup_index < PaletteEntries) begin
          r.palette_rgb = clut[w.lookup_index];
        end
      end
      OP_READ_ROWS: r.read_data = words_reg;
      default: ;
    endcase
    r.pixel_format = fmt_cur;
    r.row_stride   = stride_cur;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [23:0] want_v, input logic [23:0] got_v);
    if (want_v !== got_v) begin
      $error("%s expected %0h actual %0h", name, want_v, got_v);
      errors_o++;
    end
  endtask

  // signals only move at the rising edge, so the falling edge sees what the next edge takes
  always @(negedge clk_i) begin
    out_word_t want;
    if (!rst_ni) begin
      reset_registers();
      expected_results.delete();
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          $error("result word with no access waiting");
          errors_o++;
        end else begin
          want = expected_results.pop_front();
          check_field("read_data", 24'(want.read_data), 24'(out_word_i.read_data));
          check_field("palette_rgb", want.palette_rgb, out_word_i.palette_rgb);
          check_field("pixel_format", 24'(want.pixel_format), 24'(out_word_i.pixel_format));
          check_field("row_stride", 24'(want.row_stride), 24'(out_word_i.row_stride));
          check_field("changed", 24'(want.changed), 24'(out_word_i.changed));
        end
      end
      if (in_valid_i && !in_stall_i) begin
        expected_results.push_back(apply_access(in_word_i));
      end
    end
    pending_o = expected_results.size();
  end

endmodule

// ===== tb/tb_top.sv =====
// top of the ramdac palette/format testbench: clock, reset, register access stimulus, verdict
module tb_top;
  import rpf_pkg::*;

  localparam int CycleLimit  = 200000;
  localparam int RandomItems = 1330;

  logic      clk_i = 1'b0;
  logic      rst_n;
  logic      in_valid;
  in_word_t  in_word;
  logic      in_stall;
  logic      out_valid;
  logic      out_stall;
  out_word_t out_word;

  int fails;
  int outstanding;
  int sent = 0;
  int cycles = 0;
  bit calm = 1'b0;
  bit quiet = 1'b0;
  bit long_hold_done = 1'b0;

  always #10 clk_i = ~clk_i;

  ramdac_palette_and_format_registers u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_word_i   (in_word),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_word_o  (out_word)
  );

  palette_format_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .in_word_i   (in_word),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .out_word_i  (out_word),
    .errors_o    (fails),
    .pending_o   (outstanding)
  );

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // offers one access word and returns once it is taken
  task automatic offer(input logic [2:0] op, input logic [15:0] value, input logic [7:0] lut_idx);
    bit stalled;
    if (!quiet && !calm && $urandom_range(0, 6) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    in_word  <= '{op: op, value: value, lookup_index: lut_idx};
    in_valid <= 1'b1;
    do begin
      @(negedge clk_i);
      stalled = in_stall;
      @(posedge clk_i);
    end while (stalled);
    sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (outstanding != 0) @(posedge clk_i);
  endtask

  // index write then data writes; a broken load stops short of the blue word
  task automatic palette_load(input bit broken);
    logic [7:0] at;
    int         n;
    at = 8'($urandom);
    n  = broken ? $urandom_range(0, 2) : 3;
    offer(OP_INDEX_WR, {8'($urandom), at}, 8'($urandom));
    repeat (n) offer(OP_DATA_WR, 16'($urandom), 8'($urandom));
    if (!broken && $urandom_range(0, 1) == 1) begin
      offer(OP_LOOKUP, 16'($urandom), at);
    end
  endtask

  // receiver side: short random stall bursts and one long hold-off
  initial begin
    out_stall <= 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk_i);
      if (!long_hold_done && sent >= 400) begin
        long_hold_done = 1'b1;
        out_stall <= 1'b1;
        repeat (64) @(posedge clk_i);
        out_stall <= 1'b0;
      end else if (!quiet && !calm && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 5)) @(posedge clk_i);
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    int stop_at;
    int next_pause;
    int pick;
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_word  <= '0;
    repeat (11) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    // reset values, wrap of the index, ignored high bytes
    offer(OP_READ_IDX, 16'hFFFF, 8'hFF);
    offer(OP_LOOKUP, 16'h0000, 8'hFF);
    offer(OP_INDEX_WR, 16'hFFFF, 8'h00);
    offer(OP_DATA_WR, 16'hFF12, 8'h00);
    offer(OP_DATA_WR, 16'h0034, 8'h00);
    offer(OP_DATA_WR, 16'hAB56, 8'h00);
    offer(OP_READ_IDX, 16'h0000, 8'h00);
    repeat (3) offer(OP_DATA_WR, 16'hFFFF, 8'hFF);
    offer(OP_LOOKUP, 16'hFFFF, 8'h00);
    offer(OP_LOOKUP, 16'h0000, 8'hFF);
    // index write in the middle of a load restarts at red
    offer(OP_INDEX_WR, 16'h0080, 8'h00);
    offer(OP_DATA_WR, 16'h0011, 8'h00);
    offer(OP_DATA_WR, 16'h0022, 8'h00);
    offer(OP_INDEX_WR, 16'h0081, 8'h00);
    offer(OP_DATA_WR, 16'h0033, 8'h00);
    offer(OP_DATA_WR, 16'h0044, 8'h00);
    offer(OP_DATA_WR, 16'h0055, 8'h00);
    offer(OP_LOOKUP, 16'h0000, 8'h81);
    offer(OP_LOOKUP, 16'h0000, 8'h80);
    // same format again, packed 32 bpp, stride extremes
    offer(OP_FORMAT_WR, 16'h0018, 8'h00);
    offer(OP_FORMAT_WR, 16'h001A, 8'h00);
    offer(OP_ROWS_WR, 16'hFFFF, 8'h00);
    offer(OP_ROWS_WR, 16'h0000, 8'h00);
    offer(OP_FORMAT_WR, 16'hFFFD, 8'h00);
    offer(OP_FORMAT_WR, 16'h0000, 8'h00);
    offer(OP_READ_FMT, 16'hFFFF, 8'hFF);
    offer(OP_READ_ROWS, 16'hFFFF, 8'hFF);
    drain();

    stop_at    = sent + RandomItems;
    next_pause = sent + 300;
    while (sent < stop_at) begin
      if (sent >= next_pause) begin
        next_pause += 300;
        drain();
        calm = ($urandom_range(0, 3) == 0);
      end
      quiet = (sent >= stop_at - 150);
      pick  = $urandom_range(0, 99);
      if (pick < 45) begin
        palette_load(1'b0);
      end else if (pick < 55) begin
        palette_load(1'b1);
      end else if (pick < 68) begin
        offer(OP_FORMAT_WR, 16'($urandom), 8'($urandom));
      end else if (pick < 76) begin
        offer(OP_ROWS_WR, 16'($urandom), 8'($urandom));
      end else if (pick < 88) begin
        offer(OP_LOOKUP, 16'($urandom), 8'($urandom));
      end else begin
        offer(3'($urandom), 16'($urandom), 8'($urandom));
      end
    end

    drain();
    repeat (8) @(posedge clk_i);
    if (fails == 0 && outstanding == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
